// ===== rtl/uwtl_pkg.sv =====
// Shared types, constants and helpers of the UTF-8 word tokenizer.
`default_nettype none
package uwtl_pkg;

	localparam int COUNT_WIDTH = 32;
	localparam int RES_DEPTH   = 3;
	localparam int TOTAL_WIDTH = 32;

	localparam logic [7:0] LEAD_D0  = 8'hD0;
	localparam logic [7:0] LEAD_D1  = 8'hD1;
	localparam logic [7:0] YO_UPPER = 8'h81;
	localparam logic [7:0] YO_LOWER = 8'h91;
	localparam logic [7:0] CASE_OFS = 8'h20;

	localparam logic KIND_LETTER = 1'b0;
	localparam logic KIND_MARKER = 1'b1;

	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [1:0]             res_cnt_t;
	typedef logic [1:0]             res_idx_t;

	typedef struct packed {
		logic                   kind;
		logic [7:0]             data;
		logic [TOTAL_WIDTH-1:0] total;
		logic                   last;
	} res_t;

	function automatic count_t sat_inc(input count_t v);
		return (v == '1) ? v : v + COUNT_WIDTH'(1);
	endfunction

	function automatic logic [TOTAL_WIDTH-1:0] clamp_total(input count_t v);
		logic [63:0] ext;
		ext = 64'(v);
		return (ext > 64'h0000_0000_FFFF_FFFF) ? '1 : ext[TOTAL_WIDTH-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/utf8_word_tokenizer_lowercase_top.sv =====
// Top level of the UTF-8 lowercasing word tokenizer.
//
// Usage:
//  s_* channel carries one text byte per request: s_tdata[7:0] is the byte,
//  s_tlast marks the last byte of a text.
//  m_* channel carries results: m_tuser is the kind (0 letter, 1 word-end
//  marker), m_tdata[7:0] the lowercase byte, m_tdata[39:8] the word total,
//  m_tlast flags the last result caused by one input byte.
//  cfg_we/cfg_wdata write mode_normalize (0 split into words, 1 one word per
//  text); write only while the block is idle.
// Timing:
//  An accepted byte is decoded in the same cycle and its 0..3 results are
//  loaded into a three-entry result buffer; the first result shows on m_*
//  the next cycle, then one result per cycle while m_tready is high.
//  Throughput is one byte per cycle while each byte yields at most one
//  result and m_tready is high; a byte with more results holds the input
//  until the single output port has drained all but its last result.
// Reset (arst_n low): buffer empty, no lead byte held, no word open, count
//  zero, split mode.
// Stall: while m_tready is low the current result holds; s_tready drops
//  until the buffer is empty or its last result leaves in this cycle.
`default_nettype none
module utf8_word_tokenizer_lowercase_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire         cfg_wdata,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] in_byte
	input  wire         s_tlast,   // text_end
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [39:0] m_tdata,   // [7:0] out_byte, [39:8] word_total
	output logic        m_tuser,   // out_kind
	output logic        m_tlast    // run_end
);
	import uwtl_pkg::*;

	// tokenizer state
	logic   mode_q;
	logic   lead_pending_q;
	logic   lead_is_d1_q;
	logic   word_open_q;
	count_t words_q;

	// result buffer
	res_t     buf_q [RES_DEPTH];
	res_cnt_t left_q;
	res_idx_t rd_q;

	// decode of the incoming request
	res_t     res [RES_DEPTH];
	res_cnt_t n;
	logic     wo;
	count_t   words;
	logic     lp_n;
	logic     d1_n;
	logic     pair_ok;
	logic     do_fresh;
	logic [7:0] first;
	logic [7:0] second;
	logic [7:0] b;
	logic     in_fire;
	logic     out_fire;

	assign b        = s_tdata;
	assign m_tvalid = (left_q != '0);
	assign out_fire = m_tvalid && m_tready;
	assign s_tready = (left_q == '0) || ((left_q == res_cnt_t'(1)) && m_tready);
	assign in_fire  = s_tvalid && s_tready;

	assign m_tuser = buf_q[rd_q].kind;
	assign m_tdata = {buf_q[rd_q].total, buf_q[rd_q].data};
	assign m_tlast = buf_q[rd_q].last;

	always_comb begin
		for (int i = 0; i < RES_DEPTH; i++) begin
			res[i] = '0;
		end
		n        = '0;
		wo       = word_open_q;
		words    = words_q;
		lp_n     = 1'b0;
		d1_n     = 1'b0;
		pair_ok  = 1'b0;
		first    = 8'h00;
		second   = 8'h00;

		// pair check against the held lead byte
		if (lead_pending_q) begin
			if (!lead_is_d1_q) begin
				if (b == YO_UPPER) begin
					pair_ok = 1'b1; first = LEAD_D1; second = YO_LOWER;
				end else if (b inside {[8'h90:8'h9F]}) begin
					pair_ok = 1'b1; first = LEAD_D0; second = b + CASE_OFS;
				end else if (b inside {[8'hA0:8'hAF]}) begin
					pair_ok = 1'b1; first = LEAD_D1; second = b - CASE_OFS;
				end else if (b inside {[8'hB0:8'hBF]}) begin
					pair_ok = 1'b1; first = LEAD_D0; second = b;
				end
			end else if ((b inside {[8'h80:8'h8F]}) || (b == YO_LOWER)) begin
				pair_ok = 1'b1; first = LEAD_D1; second = b;
			end
		end
		do_fresh = !lead_pending_q || !pair_ok;

		if (lead_pending_q && pair_ok) begin
			res[n].kind = KIND_LETTER; res[n].data = first;  n = n + res_cnt_t'(1);
			res[n].kind = KIND_LETTER; res[n].data = second; n = n + res_cnt_t'(1);
			wo = 1'b1;
		end
		// unpaired lead closes the word, byte is then judged afresh
		if (lead_pending_q && !pair_ok) begin
			if (!mode_q && wo) begin
				words = sat_inc(words);
				res[n].kind  = KIND_MARKER;
				res[n].total = clamp_total(words);
				n = n + res_cnt_t'(1);
			end
			wo = 1'b0;
		end

		if (do_fresh) begin
			if (b inside {[8'h41:8'h5A]}) begin
				res[n].kind = KIND_LETTER; res[n].data = b + CASE_OFS; n = n + res_cnt_t'(1);
				wo = 1'b1;
			end else if (b inside {[8'h61:8'h7A]}) begin
				res[n].kind = KIND_LETTER; res[n].data = b; n = n + res_cnt_t'(1);
				wo = 1'b1;
			end else if (((b == LEAD_D0) || (b == LEAD_D1)) && !s_tlast) begin
				lp_n = 1'b1;
				d1_n = b[0];
			end else begin
				if (!mode_q && wo) begin
					words = sat_inc(words);
					res[n].kind  = KIND_MARKER;
					res[n].total = clamp_total(words);
					n = n + res_cnt_t'(1);
				end
				wo = 1'b0;
			end
		end

		// end of text: final marker in normalize mode or if a word is open, then everything starts over
		if (s_tlast) begin
			if (mode_q || wo) begin
				words = sat_inc(words);
				res[n].kind  = KIND_MARKER;
				res[n].total = clamp_total(words);
				n = n + res_cnt_t'(1);
			end
			lp_n  = 1'b0;
			d1_n  = 1'b0;
			wo    = 1'b0;
			words = '0;
		end

		if (n != '0) begin
			res[n - res_cnt_t'(1)].last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= 1'b0;
			lead_pending_q <= 1'b0;
			lead_is_d1_q   <= 1'b0;
			word_open_q    <= 1'b0;
			words_q        <= '0;
			left_q         <= '0;
			rd_q           <= '0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (in_fire) begin
				lead_pending_q <= lp_n;
				lead_is_d1_q   <= d1_n;
				word_open_q    <= wo;
				words_q        <= words;
				left_q         <= n;
				rd_q           <= '0;
			end else if (out_fire) begin
				left_q <= left_q - res_cnt_t'(1);
				rd_q   <= rd_q + res_idx_t'(1);
			end
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_fire) begin
			for (int i = 0; i < RES_DEPTH; i++) begin
				buf_q[i] <= res[i];
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/uwtl_checker.sv =====
// Port-level checks of the tokenizer, bound to the top level.
`default_nettype none
module uwtl_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire [7:0]  s_tdata,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [39:0] m_tdata,
	input wire        m_tuser,
	input wire        m_tlast
);

	// held result must not change while stalled
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled result changed");

	// input only taken when the buffer is free or a result leaves in this cycle
	a_ready_gate: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid || m_tready)
		else $error("input ready while results wait");

	// an ASCII letter always yields a result the next cycle
	a_letter_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready &&
		((s_tdata >= 8'h41 && s_tdata <= 8'h5A) || (s_tdata >= 8'h61 && s_tdata <= 8'h7A))
		|=> m_tvalid)
		else $error("ASCII letter gave no result");

	// letters never leave in uppercase
	a_lowercase: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> !(m_tdata[7:0] >= 8'h41 && m_tdata[7:0] <= 8'h5A))
		else $error("uppercase letter emitted");

endmodule

bind utf8_word_tokenizer_lowercase_top uwtl_checker u_uwtl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the UTF-8 lowercasing word tokenizer.
`timescale 1ns / 100ps
`default_nettype none
module tb;
	import uwtl_pkg::*;

	// Clock, reset, and block ports. Every input starts at a known value.
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_wdata = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;   // [7:0] in_byte
	logic        s_tlast = 1'b0;    // text_end
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;           // [7:0] out_byte, [39:8] word_total
	logic        m_tuser;           // out_kind
	logic        m_tlast;           // run_end

	// One text byte waiting to be offered on the request side.
	typedef struct packed {
		logic       tend;
		logic [7:0] chr;
	} text_byte_t;

	text_byte_t text_q[$];      // bytes not yet offered
	res_t       tokens_due[$];  // lowercase tokens and markers still to come
	int         queued = 0;     // bytes queued so far, used to size the random part
	int         errors = 0;

	// Idle knobs: percent of cycles the sender idles / the receiver stalls.
	int         gap_pct = 0;
	int         stall_pct = 0;
	logic       recv_hold = 1'b0;  // long receiver hold-off, owned by its own process
	bit         hold_go = 1'b0;

	// Shadow of the tokenizer state and its mode register.
	logic       mode_norm = 1'b0;
	logic       lead_held = 1'b0;
	logic       lead_d1 = 1'b0;
	logic       word_open = 1'b0;
	count_t     words_done = '0;
	res_t       step_res[0:2];     // results of the byte being predicted
	int         step_n;

	utf8_word_tokenizer_lowercase_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------
	// Token predictor
	// ---------------------------------------------------------------
	function automatic void emit(input logic kind, input logic [7:0] b, input count_t total);
		step_res[step_n].kind  = kind;
		step_res[step_n].data  = b;
		step_res[step_n].total = total;
		step_res[step_n].last  = 1'b0;
		step_n++;
	endfunction

	// Count saturates at all ones.
	function automatic void bump_words();
		if (words_done != '1)
			words_done = words_done + 1'b1;
	endfunction

	function automatic void put_letter(input logic [7:0] b);
		emit(KIND_LETTER, b, '0);
		word_open = 1'b1;
	endfunction

	// Separator: split mode closes an open word with a marker.
	function automatic void close_word();
		if (!mode_norm && word_open) begin
			bump_words();
			emit(KIND_MARKER, 8'h00, words_done);
		end
		word_open = 1'b0;
	endfunction

	// Byte seen with no lead byte held. A lead at text end is a separator.
	function automatic void judge_fresh(input logic [7:0] b, input logic tend);
		if (b >= 8'h41 && b <= 8'h5A) begin
			put_letter(b + CASE_OFS);
		end else if (b >= 8'h61 && b <= 8'h7A) begin
			put_letter(b);
		end else if ((b == LEAD_D0 || b == LEAD_D1) && !tend) begin
			lead_held = 1'b1;
			lead_d1   = b[0];
		end else begin
			close_word();
		end
	endfunction

	// Works out every result of one accepted byte and queues them.
	function automatic void tokenize_byte(input logic [7:0] b, input logic tend);
		logic       ok;
		logic [7:0] hi, lo;
		int         i;
		step_n = 0;
		ok = 1'b1;
		hi = 8'h00;
		lo = 8'h00;
		if (lead_held) begin
			if (!lead_d1) begin
				if (b == YO_UPPER) begin
					hi = LEAD_D1; lo = YO_LOWER;
				end else if (b >= 8'h90 && b <= 8'h9F) begin
					hi = LEAD_D0; lo = b + CASE_OFS;
				end else if (b >= 8'hA0 && b <= 8'hAF) begin
					hi = LEAD_D1; lo = b - CASE_OFS;
				end else if (b >= 8'hB0 && b <= 8'hBF) begin
					hi = LEAD_D0; lo = b;
				end else begin
					ok = 1'b0;
				end
			end else if ((b >= 8'h80 && b <= 8'h8F) || b == YO_LOWER) begin
				hi = LEAD_D1; lo = b;
			end else begin
				ok = 1'b0;
			end
			lead_held = 1'b0;
			lead_d1   = 1'b0;
			if (ok) begin
				put_letter(hi);
				put_letter(lo);
			end else begin
				// unpaired lead: separator, then the byte is judged on its own
				close_word();
				judge_fresh(b, tend);
			end
		end else begin
			judge_fresh(b, tend);
		end
		if (tend) begin
			// normalize mode always closes the text with one marker, even if empty
			if (mode_norm) begin
				bump_words();
				emit(KIND_MARKER, 8'h00, words_done);
			end else begin
				close_word();
			end
			lead_held  = 1'b0;
			lead_d1    = 1'b0;
			word_open  = 1'b0;
			words_done = '0;
		end
		if (step_n > 0)
			step_res[step_n-1].last = 1'b1;
		for (i = 0; i < step_n; i++)
			tokens_due.insert(tokens_due.size(), step_res[i]);
	endfunction

	// ---------------------------------------------------------------
	// Request driver: offers queued bytes, predicts on acceptance.
	// ---------------------------------------------------------------
	always @(posedge clk) begin : drive
		text_byte_t nxt;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				tokenize_byte(s_tdata, s_tlast);
			if (!s_tvalid || s_tready) begin
				if (text_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
					nxt = text_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= nxt.chr;
					s_tlast  <= nxt.tend;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Result monitor: checks each accepted result against the oldest
	// expectation, field by field, and drives random backpressure.
	// ---------------------------------------------------------------
	always @(posedge clk) begin : watch
		res_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (tokens_due.size() == 0) begin
					$display("%0t: unexpected result kind %0b byte %h total %0d last %0b",
						$time, m_tuser, m_tdata[7:0], m_tdata[39:8], m_tlast);
					errors++;
				end else begin
					want = tokens_due.pop_front();
					if (m_tuser !== want.kind) begin
						$display("%0t: out_kind expected %0b got %0b", $time, want.kind, m_tuser);
						errors++;
					end
					if (m_tdata[7:0] !== want.data) begin
						$display("%0t: out_byte expected %h got %h",
							$time, want.data, m_tdata[7:0]);
						errors++;
					end
					if (m_tdata[39:8] !== want.total) begin
						$display("%0t: word_total expected %0d got %0d",
							$time, want.total, m_tdata[39:8]);
						errors++;
					end
					if (m_tlast !== want.last) begin
						$display("%0t: run_end expected %0b got %0b", $time, want.last, m_tlast);
						errors++;
					end
				end
			end
			m_tready <= !recv_hold && ($urandom_range(99) >= stall_pct);
		end
	end

	// Long receiver hold-off: lets the result buffer fill and stall the input.
	initial begin : hold_off
		wait (hold_go);
		@(posedge clk);
		recv_hold <= 1'b1;
		repeat (80) @(posedge clk);
		recv_hold <= 1'b0;
	end

	// Hard stop in case the block hangs.
	initial begin : watchdog
		#3_000_000;
		$display("tb: failure");
		$finish;
	end

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------
	task automatic push_byte(input logic [7:0] b, input logic tend);
		text_byte_t t;
		t.chr  = b;
		t.tend = tend;
		text_q.insert(text_q.size(), t);
		queued++;
	endtask

	// Waits until every queued byte is accepted and every token has come.
	task automatic wait_drain();
		while (text_q.size() != 0 || s_tvalid || tokens_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_mode(input logic v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		mode_norm = v;   // register takes the value at this edge
	endtask

	task automatic set_idle(input int gap, input int stall);
		@(posedge clk);
		gap_pct   <= gap;
		stall_pct <= stall;
	endtask

	function automatic logic [7:0] ascii_letter();
		if ($urandom_range(1))
			return 8'($urandom_range(8'h5A, 8'h41));
		return 8'($urandom_range(8'h7A, 8'h61));
	endfunction

	// One letter: plain ASCII, a well-formed Cyrillic pair, or a broken pair.
	task automatic push_letter();
		int pick;
		pick = $urandom_range(9);
		if (pick < 4) begin
			push_byte(ascii_letter(), 1'b0);
		end else if (pick < 8) begin
			case ($urandom_range(5))
				0: begin push_byte(LEAD_D0, 1'b0); push_byte(YO_UPPER, 1'b0); end
				1: begin push_byte(LEAD_D0, 1'b0); push_byte(8'($urandom_range(8'h9F, 8'h90)), 1'b0); end
				2: begin push_byte(LEAD_D0, 1'b0); push_byte(8'($urandom_range(8'hAF, 8'hA0)), 1'b0); end
				3: begin push_byte(LEAD_D0, 1'b0); push_byte(8'($urandom_range(8'hBF, 8'hB0)), 1'b0); end
				4: begin push_byte(LEAD_D1, 1'b0); push_byte(8'($urandom_range(8'h8F, 8'h80)), 1'b0); end
				default: begin push_byte(LEAD_D1, 1'b0); push_byte(YO_LOWER, 1'b0); end
			endcase
		end else begin
			push_byte($urandom_range(1) ? LEAD_D1 : LEAD_D0, 1'b0);
			push_byte(8'($urandom_range(255)), 1'b0);
		end
	endtask

	task automatic push_gap();
		int k;
		for (k = 0; k < $urandom_range(2, 1); k++)
			case ($urandom_range(3))
				0: push_byte(8'h20, 1'b0);
				1: push_byte(8'h2C, 1'b0);
				2: push_byte(8'($urandom_range(8'h39, 8'h30)), 1'b0);
				default: push_byte(8'($urandom_range(255)), 1'b0);
			endcase
	endtask

	// A whole text: words with random content, closed by a text-end byte.
	task automatic push_text();
		int words, w, k;
		words = $urandom_range(4);
		if ($urandom_range(3) == 0)
			push_gap();
		for (w = 0; w < words; w++) begin
			for (k = 0; k < $urandom_range(5, 1); k++)
				push_letter();
			if (w != words - 1)
				push_gap();
		end
		case ($urandom_range(3))
			0: push_byte(8'($urandom_range(8'h40, 8'h00)), 1'b1);
			1: push_byte(ascii_letter(), 1'b1);
			2: push_byte($urandom_range(1) ? LEAD_D1 : LEAD_D0, 1'b1);
			default: begin
				push_byte(LEAD_D0, 1'b0);
				push_byte(8'($urandom_range(8'hBF, 8'h90)), 1'b1);
			end
		endcase
	endtask

	// Mostly whole texts; about one pick in ten is a single raw noise byte.
	task automatic fill_random(input int n);
		int goal;
		goal = queued + n;
		while (queued < goal)
			if ($urandom_range(9) == 0)
				push_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
			else
				push_text();
	endtask

	// ---------------------------------------------------------------
	// Test sequence
	// ---------------------------------------------------------------
	initial begin : main_seq
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed, split mode, no idling.
		write_mode(1'b0);
		push_byte(8'h41, 1'b0);                          // 'A' lowest capital
		push_byte(8'h7A, 1'b0);                          // 'z' highest small
		push_byte(8'h5B, 1'b0);                          // just past 'Z': separator
		push_byte(8'h5A, 1'b0);
		push_byte(LEAD_D0, 1'b0); push_byte(YO_UPPER, 1'b0);  // capital yo
		push_byte(LEAD_D0, 1'b0); push_byte(8'h90, 1'b0);
		push_byte(LEAD_D0, 1'b0); push_byte(8'hAF, 1'b0);
		push_byte(LEAD_D0, 1'b0); push_byte(8'hBF, 1'b0);     // already small
		push_byte(LEAD_D1, 1'b0); push_byte(8'h8F, 1'b0);
		push_byte(LEAD_D1, 1'b0); push_byte(YO_LOWER, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(LEAD_D0, 1'b0); push_byte(8'h41, 1'b0);     // unpaired lead, then a letter
		push_byte(LEAD_D1, 1'b0); push_byte(LEAD_D0, 1'b0);   // unpaired lead, then a new lead
		push_byte(8'h9F, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(LEAD_D0, 1'b1);                        // lead byte at text end
		wait_drain();

		// Directed, normalize mode, including an empty text.
		write_mode(1'b1);
		push_byte(8'h41, 1'b0);
		push_byte(8'h20, 1'b0);                          // dropped
		push_byte(LEAD_D0, 1'b0); push_byte(8'hA0, 1'b0);
		push_byte(8'hFF, 1'b1);
		push_byte(8'h20, 1'b1);                          // empty text still gets a marker
		push_byte(8'h62, 1'b0);                          // word left open
		wait_drain();
		// Mode flips mid-text: the open word is closed the split way.
		write_mode(1'b0);
		push_byte(8'h20, 1'b0);
		push_byte(8'h5A, 1'b1);
		wait_drain();

		// Random phases across modes and idle patterns.
		set_idle(0, 0);
		fill_random(28);
		wait_drain();

		write_mode(1'b1);
		set_idle(68, 0);
		fill_random(28);
		wait_drain();

		write_mode(1'b0);
		set_idle(0, 68);
		fill_random(28);
		wait_drain();

		write_mode(1'b1);
		set_idle(14, 14);
		fill_random(28);
		wait_drain();

		// Backpressure: receiver holds off while the sender keeps offering.
		write_mode(1'b0);
		set_idle(0, 0);
		hold_go = 1'b1;
		fill_random(18);
		wait_drain();
		// Sender has paused until every token arrived; finish with a last batch.
		fill_random(10);
		wait_drain();
		repeat (6) @(posedge clk);

		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
`default_nettype wire
